@@ sv/sfp_pkg.sv @@
// Shared constants and types for the serial frame parser with XOR frame check.
package sfp_pkg;

   localparam logic [7:0] START_BYTE = 8'hFE;
   localparam int MAX_PAYLOAD = 64;
   localparam int STORE_DEPTH = 64;
   localparam int LEN_W = 7;
   localparam int POS_W = 6;
   localparam int RAM_DEPTH = 2 * STORE_DEPTH;
   localparam int RAM_AW = POS_W + 1;

   typedef struct packed {
      logic [7:0]       cmd_hi;
      logic [7:0]       cmd_lo;
      logic [LEN_W-1:0] len;
      logic             bank;
   } frame_desc_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic           push;
      frame_desc_type desc;
   } desc_push_type;

endpackage

@@ sv/serial_frame_parser_xor_fcs.sv @@
// Serial frame parser with XOR frame check: top level.
// Input channel (req_*): one received byte per beat. The parser hunts for
// the start byte 0xFE, then takes length, two command bytes, the payload
// and the XOR check byte. Bytes are taken one per cycle unless stalled.
// Result channel (rsp_*): a good frame gives one beat per payload byte,
// rsp_last on the final one; an empty frame gives one beat with
// rsp_has_data low.
// After the edge that accepts its check byte, the first beat of a frame passes
// the descriptor queue, a registered RAM read with one stage and the output
// register to rsp_valid; the run drains at one beat per cycle unless stalled.
// Throughput: one byte per cycle. The payload store holds two banks, so one
// frame can drain while the next one fills; with both banks owned by frames
// not yet fully read out, req_ready drops on payload and check bytes until
// the back end has issued the last read of the oldest frame.
// A stalled receiver holds the output register; the front end keeps parsing
// until both banks are taken.
// Reset (synchronous, active high) returns the parser to hunting and
// empties the descriptor queue and the output stage; no clearing pass.
module serial_frame_parser_xor_fcs
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_command_high,
   output logic [7:0]       rsp_command_low,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic             rsp_has_data,
   output logic [7:0]       rsp_data_byte,
   output logic [POS_W-1:0] rsp_byte_position,
   output logic             rsp_last
);

   ram_wr_type        ram_wr;
   desc_push_type     desc_push;
   frame_desc_type    q_head;
   logic              q_valid, q_full, pop;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   sfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .ram_wr      (ram_wr),
      .desc_push   (desc_push)
   );

   sfp_ram #(
      .DATA_W (8),
      .DEPTH  (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .desc_push (desc_push),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .q_head    (q_head)
   );

   sfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .pop                (pop),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command_high   (rsp_command_high),
      .rsp_command_low    (rsp_command_low),
      .rsp_payload_length (rsp_payload_length),
      .rsp_has_data       (rsp_has_data),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_last           (rsp_last)
   );

endmodule

@@ sv/sfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sfp_front.sv @@
// Front end: byte parser, payload store writes and frame descriptor push.
module sfp_front
   import sfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_rx_byte,
   input  logic          q_full,
   output ram_wr_type    ram_wr,
   output desc_push_type desc_push
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_LEN, PH_CMD_HI, PH_CMD_LO, PH_DATA, PH_CHECK
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       cmd_hi_ff, cmd_hi_in;
   logic [7:0]       cmd_lo_ff, cmd_lo_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       chk_ff, chk_in;
   logic             bank_ff, bank_in;
   logic             beat;
   logic [LEN_W-1:0] fill_next;
   logic [7:0]       b;

   assign b = req_rx_byte;
   assign req_ready = !(((phase_ff == PH_DATA) || (phase_ff == PH_CHECK)) && q_full);
   assign beat = req_valid && req_ready;
   assign fill_next = fill_ff + LEN_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      cmd_hi_in = cmd_hi_ff;
      cmd_lo_in = cmd_lo_ff;
      fill_in   = fill_ff;
      chk_in    = chk_ff;
      bank_in   = bank_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = {bank_ff, fill_ff[POS_W-1:0]};
      ram_wr.data = b;
      desc_push.push = 1'b0;
      desc_push.desc.cmd_hi = cmd_hi_ff;
      desc_push.desc.cmd_lo = cmd_lo_ff;
      desc_push.desc.len    = len_ff;
      desc_push.desc.bank   = bank_ff;
      if (beat) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == START_BYTE) phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (b > 8'(MAX_PAYLOAD)) begin
                  phase_in = (b == START_BYTE) ? PH_LEN : PH_HUNT;
                  len_in = '0; cmd_hi_in = '0; cmd_lo_in = '0; fill_in = '0; chk_in = '0;
               end else begin
                  len_in   = b[LEN_W-1:0];
                  chk_in   = b;
                  phase_in = PH_CMD_HI;
               end
            end
            PH_CMD_HI: begin
               cmd_hi_in = b;
               chk_in    = chk_ff ^ b;
               phase_in  = PH_CMD_LO;
            end
            PH_CMD_LO: begin
               cmd_lo_in = b;
               chk_in    = chk_ff ^ b;
               fill_in   = '0;
               phase_in  = (len_ff != '0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
               ram_wr.en = 1'b1;
               chk_in    = chk_ff ^ b;
               fill_in   = fill_next;
               if (fill_next >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (chk_ff != b) begin
                  phase_in = (b == START_BYTE) ? PH_LEN : PH_HUNT;
               end else begin
                  desc_push.push = 1'b1;
                  bank_in  = !bank_ff;
                  phase_in = PH_HUNT;
               end
               len_in = '0; cmd_hi_in = '0; cmd_lo_in = '0; fill_in = '0; chk_in = '0;
            end
            default: begin
               phase_in = PH_HUNT;
               len_in = '0; cmd_hi_in = '0; cmd_lo_in = '0; fill_in = '0; chk_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         len_ff    <= '0;
         cmd_hi_ff <= '0;
         cmd_lo_ff <= '0;
         fill_ff   <= '0;
         chk_ff    <= '0;
         bank_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         cmd_hi_ff <= cmd_hi_in;
         cmd_lo_ff <= cmd_lo_in;
         fill_ff   <= fill_in;
         chk_ff    <= chk_in;
         bank_ff   <= bank_in;
      end
   end

endmodule

@@ sv/sfp_queue.sv @@
// Two-entry queue of accepted frame descriptors, one per payload bank.
module sfp_queue
   import sfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  desc_push_type  desc_push,
   input  logic           pop,
   output logic           q_valid,
   output logic           q_full,
   output frame_desc_type q_head
);

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_pop;

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ desc_push.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(desc_push.push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (desc_push.push) begin
         entry_ff[wr_ptr_ff] <= desc_push.desc;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/sfp_back.sv @@
// Back end: reads the payload bank of the head frame and drives result beats.
module sfp_back
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  frame_desc_type   q_head,
   output logic             pop,
   output logic             rd_en,
   output logic [RAM_AW-1:0] rd_addr,
   input  logic [7:0]       rd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_command_high,
   output logic [7:0]       rsp_command_low,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic             rsp_has_data,
   output logic [7:0]       rsp_data_byte,
   output logic [POS_W-1:0] rsp_byte_position,
   output logic             rsp_last
);

   logic [POS_W-1:0] idx_ff, idx_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_cmd_hi_ff, s1_cmd_lo_ff;
   logic [LEN_W-1:0] s1_len_ff;
   logic             s1_has_ff, s1_last_ff;
   logic [POS_W-1:0] s1_pos_ff;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_cmd_hi_ff, out_cmd_lo_ff, out_data_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic             out_has_ff, out_last_ff;
   logic [POS_W-1:0] out_pos_ff;
   logic             out_load, issue, issue_last, issue_has;

   assign out_load   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign issue      = q_valid && (!s1_valid_ff || out_load);
   assign issue_has  = (q_head.len != '0);
   assign issue_last = !issue_has || ((LEN_W'(idx_ff) + LEN_W'(1)) == q_head.len);
   assign pop        = issue && issue_last;
   assign rd_en      = issue;
   assign rd_addr    = {q_head.bank, idx_ff};

   always_comb begin
      idx_in = idx_ff;
      if (issue) idx_in = issue_last ? '0 : idx_ff + POS_W'(1);
      s1_valid_in  = issue || (s1_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_cmd_hi_ff <= q_head.cmd_hi;
         s1_cmd_lo_ff <= q_head.cmd_lo;
         s1_len_ff    <= q_head.len;
         s1_has_ff    <= issue_has;
         s1_last_ff   <= issue_last;
         s1_pos_ff    <= idx_ff;
      end
      if (out_load) begin
         out_cmd_hi_ff <= s1_cmd_hi_ff;
         out_cmd_lo_ff <= s1_cmd_lo_ff;
         out_len_ff    <= s1_len_ff;
         out_has_ff    <= s1_has_ff;
         out_last_ff   <= s1_last_ff;
         out_pos_ff    <= s1_pos_ff;
         out_data_ff   <= s1_has_ff ? rd_data : 8'd0;
      end
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command_high   = out_cmd_hi_ff;
   assign rsp_command_low    = out_cmd_lo_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_has_data       = out_has_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_byte_position  = out_pos_ff;
   assign rsp_last           = out_last_ff;

endmodule

@@ sv/sfp_checker.sv @@
// Port-level checker for the frame parser, bound to the top level.
module sfp_checker
   import sfp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [7:0]       rsp_data_byte,
   input logic [LEN_W-1:0] rsp_payload_length,
   input logic             rsp_has_data,
   input logic [POS_W-1:0] rsp_byte_position,
   input logic             rsp_last
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_position) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_last && rsp_payload_length == '0
         && rsp_data_byte == 8'd0)
      else $error("empty frame beat malformed");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |->
         LEN_W'(rsp_byte_position) < rsp_payload_length)
      else $error("byte position beyond payload length");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |->
         rsp_last == (LEN_W'(rsp_byte_position) + LEN_W'(1) == rsp_payload_length))
      else $error("last mark misplaced");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind serial_frame_parser_xor_fcs sfp_checker u_sfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_payload_length (rsp_payload_length),
   .rsp_has_data       (rsp_has_data),
   .rsp_byte_position  (rsp_byte_position),
   .rsp_last           (rsp_last)
);

@@ tb/sv/serial_frame_parser_xor_fcs_tb.sv @@
// Self-checking testbench for the serial frame parser with XOR frame check.
module serial_frame_parser_xor_fcs_tb;
   import sfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BUDGET = 75;

   typedef enum logic [2:0] {
      SEEK_START, GET_LENGTH, GET_CMD_HIGH, GET_CMD_LOW, GET_PAYLOAD, GET_CHECK
   } parse_state_type;

   typedef struct packed {
      logic [7:0]       cmd_high;
      logic [7:0]       cmd_low;
      logic [LEN_W-1:0] length;
      logic             has_data;
      logic [7:0]       data;
      logic [POS_W-1:0] position;
      logic             last;
   } frame_beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_command_high;
   logic [7:0]       rsp_command_low;
   logic [LEN_W-1:0] rsp_payload_length;
   logic             rsp_has_data;
   logic [7:0]       rsp_data_byte;
   logic [POS_W-1:0] rsp_byte_position;
   logic             rsp_last;

   logic [7:0]     byte_queue[$];
   frame_beat_type pending_beats[$];

   // shadow parser state
   parse_state_type  shadow_state = SEEK_START;
   logic [LEN_W-1:0] shadow_len = '0;
   logic [7:0]       shadow_cmd_high = 8'h00;
   logic [7:0]       shadow_cmd_low = 8'h00;
   logic [LEN_W-1:0] shadow_fill = '0;
   logic [7:0]       shadow_xor = 8'h00;
   logic [7:0]       shadow_store[STORE_DEPTH];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int bytes_sent = 0;
   int frames_accepted = 0;
   int beats_checked = 0;

   serial_frame_parser_xor_fcs uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command_high   (rsp_command_high),
      .rsp_command_low    (rsp_command_low),
      .rsp_payload_length (rsp_payload_length),
      .rsp_has_data       (rsp_has_data),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_last           (rsp_last)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void drop_frame();
      shadow_state = SEEK_START;
      shadow_len = '0;
      shadow_cmd_high = 8'h00;
      shadow_cmd_low = 8'h00;
      shadow_fill = '0;
      shadow_xor = 8'h00;
   endfunction

   function automatic void resync(logic [7:0] b);
      drop_frame();
      if (b == START_BYTE)
         shadow_state = GET_LENGTH;
   endfunction

   // advance the shadow parser by one byte, queue the beats it produces
   function automatic void parse_byte(logic [7:0] b);
      frame_beat_type beat;
      int n;
      case (shadow_state)
         SEEK_START: begin
            if (b == START_BYTE)
               shadow_state = GET_LENGTH;
         end
         GET_LENGTH: begin
            if (b > MAX_PAYLOAD) begin
               resync(b);
            end else begin
               shadow_len = b[LEN_W-1:0];
               shadow_xor = b;
               shadow_state = GET_CMD_HIGH;
            end
         end
         GET_CMD_HIGH: begin
            shadow_cmd_high = b;
            shadow_xor ^= b;
            shadow_state = GET_CMD_LOW;
         end
         GET_CMD_LOW: begin
            shadow_cmd_low = b;
            shadow_xor ^= b;
            shadow_fill = '0;
            shadow_state = (shadow_len != 0) ? GET_PAYLOAD : GET_CHECK;
         end
         GET_PAYLOAD: begin
            shadow_store[shadow_fill[POS_W-1:0]] = b;
            shadow_xor ^= b;
            shadow_fill = shadow_fill + LEN_W'(1);
            if (shadow_fill >= shadow_len)
               shadow_state = GET_CHECK;
         end
         GET_CHECK: begin
            if (shadow_xor != b) begin
               resync(b);
            end else begin
               frames_accepted++;
               beat.cmd_high = shadow_cmd_high;
               beat.cmd_low = shadow_cmd_low;
               beat.length = shadow_len;
               if (shadow_len == 0) begin
                  beat.has_data = 1'b0;
                  beat.data = 8'h00;
                  beat.position = '0;
                  beat.last = 1'b1;
                  pending_beats.push_back(beat);
               end else begin
                  n = (shadow_len > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_len);
                  for (int k = 0; k < n; k++) begin
                     beat.has_data = 1'b1;
                     beat.data = shadow_store[k];
                     beat.position = POS_W'(k);
                     beat.last = (k == n - 1);
                     pending_beats.push_back(beat);
                  end
               end
               drop_frame();
            end
         end
         default: drop_frame();
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 8);
      else if (r < 96)
         return $urandom_range(9, 40);
      else
         return $urandom_range(41, MAX_PAYLOAD);
   endfunction

   // queue a frame with random commands and payload; keep only the first
   // 'keep' payload bytes and drop the check byte if truncated
   function automatic int queue_frame(int len, bit bad_check, int keep = -1);
      logic [7:0] fcs;
      logic [7:0] b;
      int count;
      fcs = 8'(len);
      byte_queue.push_back(START_BYTE);
      byte_queue.push_back(8'(len));
      count = 2;
      for (int i = 0; i < 2; i++) begin
         b = 8'($urandom_range(255));
         fcs ^= b;
         byte_queue.push_back(b);
         count++;
      end
      for (int i = 0; i < len; i++) begin
         if (keep >= 0 && i >= keep)
            return count;
         b = 8'($urandom_range(255));
         fcs ^= b;
         byte_queue.push_back(b);
         count++;
      end
      if (keep >= 0)
         return count;
      if (bad_check)
         fcs ^= 8'($urandom_range(1, 255));
      byte_queue.push_back(fcs);
      return count + 1;
   endfunction

   function automatic void queue_random_traffic(int budget);
      int counted;
      int r;
      int len;
      counted = 0;
      while (counted < budget) begin
         r = $urandom_range(99);
         if (r < 70) begin
            counted += queue_frame(pick_length(), 1'b0);
         end else if (r < 80) begin
            repeat ($urandom_range(1, 4))
               byte_queue.push_back(8'($urandom_range(255)));
         end else if (r < 88) begin
            counted += queue_frame(pick_length(), 1'b1);
         end else if (r < 94) begin
            byte_queue.push_back(START_BYTE);
            byte_queue.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            counted += 2;
         end else begin
            len = $urandom_range(2, 8);
            counted += queue_frame(len, 1'b0, len / 2);
         end
      end
   endfunction

   task automatic drain_byte_queue();
      while (byte_queue.size() != 0)
         @(posedge clock);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         frame_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: data %0d at position %0d", rsp_data_byte,
                   rsp_byte_position);
            mismatches++;
         end else begin
            want = pending_beats.pop_front();
            check_field("command_high", want.cmd_high, rsp_command_high);
            check_field("command_low", want.cmd_low, rsp_command_low);
            check_field("payload_length", want.length, rsp_payload_length);
            check_field("has_data", want.has_data, rsp_has_data);
            check_field("data_byte", want.data, rsp_data_byte);
            check_field("byte_position", want.position, rsp_byte_position);
            check_field("last", want.last, rsp_last);
            beats_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("serial_frame_parser_xor_fcs: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: noise, oversized length, start byte as length, minimal
      // frames at the byte extremes, bad check that is itself a start byte
      byte_queue = '{8'h00, 8'hFF, 8'h7F,
                     START_BYTE, 8'h41,
                     START_BYTE, START_BYTE, 8'h00, 8'hAA, 8'h55, 8'hFF,
                     START_BYTE, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h7E,
                     START_BYTE, 8'h00, 8'h12, 8'h34, START_BYTE,
                     8'h00, 8'h00, 8'h00, 8'h00};
      queue_random_traffic(PHASE_BUDGET);
      drain_byte_queue();

      sender_idle_pct = 79;
      queue_random_traffic(PHASE_BUDGET);
      drain_byte_queue();

      sender_idle_pct = 0;
      receiver_stall_pct = 79;
      queue_random_traffic(PHASE_BUDGET);
      drain_byte_queue();

      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      queue_random_traffic(PHASE_BUDGET);
      drain_byte_queue();

      // back pressure: receiver holds off while frames, two of them full-size, stream in
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      void'(queue_frame(MAX_PAYLOAD, 1'b0));
      void'(queue_frame(20, 1'b0));
      void'(queue_frame(MAX_PAYLOAD, 1'b0));
      void'(queue_frame(33, 1'b0));
      void'(queue_frame(0, 1'b0));
      drain_byte_queue();

      while (req_valid || pending_beats.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d bytes, %0d good frames, %0d result beats checked",
               bytes_sent, frames_accepted, beats_checked);
      $display("idle modes: none, sender, receiver, both, and a long receiver hold");
      if (mismatches == 0 && pending_beats.size() == 0)
         $display("serial_frame_parser_xor_fcs: match");
      else
         $display("serial_frame_parser_xor_fcs: mismatch");
      $finish;
   end

endmodule
